// ----- rtl/clrq_pkg.sv -----
package clrq_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_READ = 2'd1,
    OP_TAKE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [3:0] KIND_STORED     = 4'd0;
  localparam logic [3:0] KIND_DISCARDED  = 4'd1;
  localparam logic [3:0] KIND_OVERFLOW   = 4'd2;
  localparam logic [3:0] KIND_QUEUED     = 4'd3;
  localparam logic [3:0] KIND_STOP       = 4'd4;
  localparam logic [3:0] KIND_DROPPED    = 4'd5;
  localparam logic [3:0] KIND_EMPTY      = 4'd6;
  localparam logic [3:0] KIND_CMD_BYTE   = 4'd7;
  localparam logic [3:0] KIND_NONE       = 4'd8;
  localparam logic [3:0] KIND_STOP_TAKEN = 4'd9;
  localparam logic [3:0] KIND_NO_STOP    = 4'd10;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [2:0] {
    JOB_SIMPLE,
    JOB_STOP,
    JOB_LINE,
    JOB_READ,
    JOB_TAKE
  } job_type_t;

  typedef struct packed {
    job_type_t  job_type;
    logic [3:0] kind;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_COPY,
    BK_COPY_END,
    BK_READ
  } back_state_t;

  function automatic logic [7:0] stop_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0: c = 8'h53;
      2'd1: c = 8'h54;
      2'd2: c = 8'h4F;
      2'd3: c = 8'h50;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/clrq_front.sv -----
module clrq_front import clrq_pkg::*; #(
  parameter int LINE_BYTES = 32,
  localparam int LW = $clog2(LINE_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [1:0]    operation,
  input  logic [7:0]    rx_byte,
  input  logic          copy_done,
  input  logic [LW-1:0] lb_raddr,
  output logic [7:0]    lb_rdata,
  output logic [LW-1:0] copy_len,
  output logic          copy_pending,
  output logic          push,
  output job_t          job
);

  logic [7:0]    line_buf [LINE_BYTES];
  logic [LW-1:0] length, length_next;
  logic          discarding, discarding_next;
  logic          stop_match, stop_match_next;
  logic [LW-1:0] copy_len_next;
  logic          copy_pending_next;
  logic          lb_we;
  logic          is_term;

  assign is_term = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
  assign push    = accept && (operation != OP_NONE);

  always_comb begin
    length_next       = length;
    discarding_next   = discarding;
    stop_match_next   = stop_match;
    copy_len_next     = copy_len;
    copy_pending_next = copy_pending;
    lb_we             = 1'b0;
    job.job_type      = JOB_SIMPLE;
    job.kind          = KIND_EMPTY;
    if (copy_done) begin
      copy_pending_next = 1'b0;
    end
    if (accept) begin
      case (operation)
        OP_BYTE: begin
          if (is_term) begin
            length_next     = '0;
            discarding_next = 1'b0;
            if (discarding || length == '0) begin
              job.kind = KIND_EMPTY;
            end else if (stop_match && length == LW'(4)) begin
              job.job_type = JOB_STOP;
            end else begin
              job.job_type      = JOB_LINE;
              copy_len_next     = length;
              copy_pending_next = 1'b1;
            end
          end else if (discarding) begin
            job.kind = KIND_DISCARDED;
          end else if (length < LW'(LINE_BYTES - 1)) begin
            lb_we       = 1'b1;
            length_next = length + 1'b1;
            job.kind    = KIND_STORED;
            if (length == '0) begin
              stop_match_next = (rx_byte == stop_char(2'd0));
            end else if (length < LW'(4)) begin
              stop_match_next = stop_match && (rx_byte == stop_char(length[1:0]));
            end
          end else begin
            length_next     = '0;
            discarding_next = 1'b1;
            job.kind        = KIND_OVERFLOW;
          end
        end
        OP_READ: job.job_type = JOB_READ;
        OP_TAKE: job.job_type = JOB_TAKE;
        default: job.job_type = JOB_SIMPLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length       <= '0;
      discarding   <= 1'b0;
      copy_pending <= 1'b0;
    end else begin
      length       <= length_next;
      discarding   <= discarding_next;
      copy_pending <= copy_pending_next;
    end
    stop_match <= stop_match_next;
    copy_len   <= copy_len_next;
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      line_buf[length] <= rx_byte;
    end
    lb_rdata <= line_buf[lb_raddr];
  end

endmodule

// ----- rtl/clrq_job_fifo.sv -----
module clrq_job_fifo import clrq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign head  = entries[rd_ptr];
  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/clrq_back.sv -----
module clrq_back import clrq_pkg::*; #(
  parameter int LINE_BYTES = 32,
  parameter int QUEUE_DEPTH = 8,
  localparam int LW = $clog2(LINE_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fifo_empty,
  input  job_t          head,
  output logic          pop,
  output logic [LW-1:0] lb_raddr,
  input  logic [7:0]    lb_rdata,
  input  logic [LW-1:0] copy_len,
  output logic          copy_done,
  output logic          strobe,
  output logic [3:0]    kind,
  output logic [7:0]    data_byte,
  output logic          last,
  output logic          stop_pending,
  output logic [3:0]    queued_lines
);

  localparam int RW = $clog2(LINE_BYTES + 1);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH * LINE_BYTES);

  function automatic logic [AW-1:0] entry_addr(input logic [PW-1:0] ptr,
                                               input logic [LW-1:0] idx);
    return AW'(ptr) * AW'(LINE_BYTES) + AW'(idx);
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
    return (ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  logic [7:0]    store [QUEUE_DEPTH * LINE_BYTES];
  logic [7:0]    store_q;
  logic          store_re;

  back_state_t   state, state_next;
  logic [PW-1:0] rp, rp_next;
  logic [PW-1:0] wp, wp_next;
  logic [CW-1:0] count, count_next;
  logic          flag, flag_next;
  logic [LW-1:0] copy_idx, copy_idx_next;
  logic          pend_valid, pend_valid_next;
  logic [LW-1:0] pend_idx, pend_idx_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [RW-1:0] rd_idx, rd_idx_next;
  logic          rd_pend, rd_pend_next;
  logic [LW-1:0] rd_pend_idx, rd_pend_idx_next;
  logic          rd_end;
  logic          queue_full;

  logic          strobe_next;
  logic [3:0]    kind_next;
  logic [7:0]    data_byte_next;
  logic          last_next;

  assign pop        = (state == BK_IDLE) && !fifo_empty;
  assign lb_raddr   = copy_idx;
  assign queue_full = (count >= CW'(QUEUE_DEPTH)) || flag;
  assign rd_end     = rd_pend &&
                      ((store_q == 8'h00) || (rd_pend_idx == LW'(LINE_BYTES - 1)));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!fifo_empty) begin
          if (head.job_type == JOB_LINE && !queue_full) begin
            state_next = BK_COPY;
          end else if (head.job_type == JOB_READ && count != '0) begin
            state_next = BK_READ;
          end
        end
      end
      BK_COPY: begin
        if (copy_idx == copy_len) begin
          state_next = BK_COPY_END;
        end
      end
      BK_COPY_END: state_next = BK_IDLE;
      BK_READ: begin
        if (rd_end) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    rp_next          = rp;
    wp_next          = wp;
    count_next       = count;
    flag_next        = flag;
    copy_idx_next    = copy_idx;
    pend_valid_next  = 1'b0;
    pend_idx_next    = pend_idx;
    rd_ptr_next      = rd_ptr;
    rd_idx_next      = rd_idx;
    rd_pend_next     = 1'b0;
    rd_pend_idx_next = rd_pend_idx;
    store_re         = 1'b0;
    copy_done        = 1'b0;
    strobe_next      = 1'b0;
    kind_next        = KIND_NONE;
    data_byte_next   = 8'h00;
    last_next        = 1'b1;
    case (state)
      BK_IDLE: begin
        if (!fifo_empty) begin
          case (head.job_type)
            JOB_SIMPLE: begin
              strobe_next = 1'b1;
              kind_next   = head.kind;
            end
            JOB_STOP: begin
              count_next  = '0;
              rp_next     = wp;
              flag_next   = 1'b1;
              strobe_next = 1'b1;
              kind_next   = KIND_STOP;
            end
            JOB_LINE: begin
              if (queue_full) begin
                copy_done   = 1'b1;
                strobe_next = 1'b1;
                kind_next   = KIND_DROPPED;
              end else begin
                copy_idx_next = '0;
              end
            end
            JOB_READ: begin
              if (count == '0) begin
                strobe_next = 1'b1;
                kind_next   = KIND_NONE;
              end else begin
                rd_ptr_next = rp;
                rp_next     = ptr_inc(rp);
                count_next  = count - 1'b1;
                rd_idx_next = '0;
              end
            end
            JOB_TAKE: begin
              strobe_next = 1'b1;
              if (flag) begin
                flag_next  = 1'b0;
                count_next = '0;
                rp_next    = wp;
                kind_next  = KIND_STOP_TAKEN;
              end else begin
                kind_next = KIND_NO_STOP;
              end
            end
            default: ;
          endcase
        end
      end
      BK_COPY: begin
        pend_valid_next = 1'b1;
        pend_idx_next   = copy_idx;
        if (copy_idx != copy_len) begin
          copy_idx_next = copy_idx + 1'b1;
        end
      end
      BK_COPY_END: begin
        wp_next     = ptr_inc(wp);
        count_next  = count + 1'b1;
        copy_done   = 1'b1;
        strobe_next = 1'b1;
        kind_next   = KIND_QUEUED;
      end
      BK_READ: begin
        if (rd_idx < RW'(LINE_BYTES)) begin
          store_re         = 1'b1;
          rd_idx_next      = rd_idx + 1'b1;
          rd_pend_next     = !rd_end;
          rd_pend_idx_next = rd_idx[LW-1:0];
        end
        if (rd_pend) begin
          strobe_next = 1'b1;
          kind_next   = KIND_CMD_BYTE;
          if (rd_end) begin
            data_byte_next = 8'h00;
            last_next      = 1'b1;
          end else begin
            data_byte_next = store_q;
            last_next      = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      rp         <= '0;
      wp         <= '0;
      count      <= '0;
      flag       <= 1'b0;
      pend_valid <= 1'b0;
      rd_pend    <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      rp         <= rp_next;
      wp         <= wp_next;
      count      <= count_next;
      flag       <= flag_next;
      pend_valid <= pend_valid_next;
      rd_pend    <= rd_pend_next;
      strobe     <= strobe_next;
    end
    copy_idx     <= copy_idx_next;
    pend_idx     <= pend_idx_next;
    rd_ptr       <= rd_ptr_next;
    rd_idx       <= rd_idx_next;
    rd_pend_idx  <= rd_pend_idx_next;
    kind         <= kind_next;
    data_byte    <= data_byte_next;
    last         <= last_next;
    stop_pending <= flag_next;
    queued_lines <= 4'(count_next);
  end

  always_ff @(posedge clk) begin
    if (pend_valid) begin
      store[entry_addr(wp, pend_idx)] <= (pend_idx == copy_len) ? 8'h00 : lb_rdata;
    end
    if (store_re) begin
      store_q <= store[entry_addr(rd_ptr, rd_idx[LW-1:0])];
    end
  end

endmodule

// ----- rtl/command_line_receiver_queue.sv -----
// Channel   Handshake            Fields
// command   start / busy         operation, rx_byte
// result    strobe (one cycle)   kind, data_byte, last, stop_pending, queued_lines
//
// A command transfers when start is high and busy is low; up to two commands wait in
// the job queue between the front and back ends.
// A byte, take-stop or empty read gives its result once the idle back end pops its job.
// Queuing a line occupies the back end in its copy and copy-end states; busy stays high
// until that copy out of the line buffer ends. A read of L characters streams L + 1
// results on consecutive cycles.
// Reset is synchronous; the receiver cannot stall, so results are never held.
module command_line_receiver_queue import clrq_pkg::*; #(
  parameter int LINE_BYTES = 32,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic [7:0] rx_byte,
  output logic       strobe,
  output logic [3:0] kind,
  output logic [7:0] data_byte,
  output logic       last,
  output logic       stop_pending,
  output logic [3:0] queued_lines
);

  localparam int LW = $clog2(LINE_BYTES);

  logic          accept;
  logic          push;
  job_t          push_job;
  job_t          head;
  logic          pop;
  logic          fifo_empty;
  logic          fifo_full;
  logic          copy_pending;
  logic          copy_done;
  logic [LW-1:0] copy_len;
  logic [LW-1:0] lb_raddr;
  logic [7:0]    lb_rdata;

  assign busy   = fifo_full || copy_pending;
  assign accept = start && !busy;

  clrq_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .operation   (operation),
    .rx_byte     (rx_byte),
    .copy_done   (copy_done),
    .lb_raddr    (lb_raddr),
    .lb_rdata    (lb_rdata),
    .copy_len    (copy_len),
    .copy_pending(copy_pending),
    .push        (push),
    .job         (push_job)
  );

  clrq_job_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .empty   (fifo_empty),
    .full    (fifo_full)
  );

  clrq_back #(
    .LINE_BYTES (LINE_BYTES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .fifo_empty  (fifo_empty),
    .head        (head),
    .pop         (pop),
    .lb_raddr    (lb_raddr),
    .lb_rdata    (lb_rdata),
    .copy_len    (copy_len),
    .copy_done   (copy_done),
    .strobe      (strobe),
    .kind        (kind),
    .data_byte   (data_byte),
    .last        (last),
    .stop_pending(stop_pending),
    .queued_lines(queued_lines)
  );

endmodule

// ----- rtl/clrq_checker.sv -----
module clrq_checker import clrq_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       strobe,
  input logic [3:0] kind,
  input logic [7:0] data_byte,
  input logic       last,
  input logic       stop_pending,
  input logic [3:0] queued_lines
);

  // The characters of one command leave on consecutive cycles.
  a_stream_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("command stream broken before its last transfer");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind != KIND_CMD_BYTE |-> last && data_byte == 8'h00)
    else $error("single result without last mark or with data");

  a_stop_flushes: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_STOP |-> stop_pending && queued_lines == 4'd0)
    else $error("stop line did not flush the queue or set the flag");

  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_STOP_TAKEN |-> !stop_pending && queued_lines == 4'd0)
    else $error("take-stop did not clear the flag and the queue");

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_NONE |-> queued_lines == 4'd0)
    else $error("empty read reported while commands wait");

endmodule

bind command_line_receiver_queue clrq_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .strobe      (strobe),
  .kind        (kind),
  .data_byte   (data_byte),
  .last        (last),
  .stop_pending(stop_pending),
  .queued_lines(queued_lines)
);
